// ===== rtl/core/krtc_pkg.sv =====
// Shared types, constants and helpers for the keypad relay toggle controller.
package krtc_pkg;

    localparam logic [15:0] DebounceReset = 16'd50;
    localparam logic [15:0] BlinkReset    = 16'd1000;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    localparam logic [7:0] SampleIdle  = 8'hff;
    localparam logic [7:0] ByteStatus  = 8'h05;
    localparam logic [7:0] ByteLedOn   = 8'hfe;
    localparam logic [7:0] ByteLedOff  = 8'h00;
    localparam logic [7:0] ByteEnd     = 8'hff;
    localparam logic [7:0] ByteCommand = 8'h01;
    localparam logic [7:0] AllOnCount  = 8'd7;

    localparam logic [3:0] KeyNone    = 4'd0;
    localparam logic [3:0] KeyAllCmd  = 4'd8;

    // register indexes (word address bit 2)
    localparam logic RegDebounce = 1'b0;
    localparam logic RegBlink    = 1'b1;

    // what a tick asks the back end to send
    typedef enum logic [1:0] {
        K_IDLE   = 2'd0,
        K_STATUS = 2'd1,
        K_CMD1   = 2'd2,
        K_CMD2   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] led;
        logic       ind;
        t_kind      kind;
    } t_event;

    // one low bit gives key 1..8, anything else no key
    function automatic logic [3:0] decode_key(input logic [7:0] sample);
        logic [7:0] pressed;
        logic [3:0] key;
        pressed = ~sample;
        key     = KeyNone;
        for (int k = 0; k < 8; k++) begin
            if (pressed == (8'd1 << k)) begin
                key = 4'(k + 1);
            end
        end
        return key;
    endfunction

endpackage

// ===== rtl/core/krtc_front.sv =====
// Front end: debounce, blink timer, LED state and event classification per tick.
module krtc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_sample,
    input  logic [15:0]         i_debounce,
    input  logic [15:0]         i_blink,
    output krtc_pkg::t_event    o_event
);

    logic [15:0] r_press, n_press;
    logic        r_locked, n_locked;
    logic [15:0] r_blink_cnt, n_blink_cnt;
    logic        r_blink_en, n_blink_en;
    logic        r_ind, n_ind;
    logic [7:0]  r_led, n_led;
    logic [7:0]  r_on, n_on;
    logic        r_odd, n_odd;

    logic [3:0]  w_key;
    logic [7:0]  w_mask;
    logic        w_double;

    always_comb begin
        n_press     = r_press;
        n_locked    = r_locked;
        n_blink_en  = r_blink_en;
        n_ind       = r_ind;
        n_led       = r_led;
        n_on        = r_on;
        n_odd       = r_odd;
        w_key       = krtc_pkg::KeyNone;
        w_double    = 1'b0;
        w_mask      = 8'd0;

        // debounce
        if (i_sample == krtc_pkg::SampleIdle) begin
            n_locked   = 1'b0;
            n_press    = 16'd0;
            n_blink_en = 1'b1;
        end else if (!r_locked) begin
            n_press = r_press + 16'd1;
            if (n_press >= i_debounce) begin
                n_locked   = 1'b1;
                n_ind      = 1'b1;
                n_blink_en = 1'b0;
                w_key      = krtc_pkg::decode_key(i_sample);
            end
        end

        // blink timer
        n_blink_cnt = r_blink_cnt + 16'd1;
        if (n_blink_cnt >= i_blink) begin
            n_blink_cnt = 16'd0;
            if (n_blink_en) begin
                n_ind = ~n_ind;
            end
        end

        // key action
        if (w_key != krtc_pkg::KeyNone && w_key != krtc_pkg::KeyAllCmd) begin
            w_mask = 8'd1 << 3'(w_key - 4'd1);
            n_led  = r_led ^ w_mask;
            if ((n_led & w_mask) != 8'd0) begin
                n_on = r_on + 8'd1;
            end else begin
                n_on = r_on - 8'd1;
            end
        end else if (w_key == krtc_pkg::KeyAllCmd) begin
            if (r_on == krtc_pkg::AllOnCount) begin
                n_led    = 8'd0;
                n_on     = 8'd0;
                w_double = r_odd;
                n_odd    = 1'b1;
            end else if (r_odd) begin
                n_led = r_led | 8'h80;
                n_on  = krtc_pkg::AllOnCount;
                n_odd = 1'b0;
            end else begin
                n_led = 8'd0;
                n_on  = 8'd0;
                n_odd = 1'b1;
            end
        end
        n_led[7] = (n_on != 8'd0);

        o_event.led = n_led;
        o_event.ind = n_ind;
        if (w_key == krtc_pkg::KeyAllCmd) begin
            o_event.kind = w_double ? krtc_pkg::K_CMD2 : krtc_pkg::K_CMD1;
        end else if (w_key != krtc_pkg::KeyNone) begin
            o_event.kind = krtc_pkg::K_STATUS;
        end else begin
            o_event.kind = krtc_pkg::K_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press     <= 16'd0;
            r_locked    <= 1'b0;
            r_blink_cnt <= 16'd0;
            r_blink_en  <= 1'b1;
            r_ind       <= 1'b0;
            r_led       <= 8'd0;
            r_on        <= 8'd0;
            r_odd       <= 1'b1;
        end else if (i_accept) begin
            r_press     <= n_press;
            r_locked    <= n_locked;
            r_blink_cnt <= n_blink_cnt;
            r_blink_en  <= n_blink_en;
            r_ind       <= n_ind;
            r_led       <= n_led;
            r_on        <= n_on;
            r_odd       <= n_odd;
        end
    end

endmodule

// ===== rtl/core/krtc_queue.sv =====
// Event queue between the front end and the frame serializer.
module krtc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  krtc_pkg::t_event    i_data,
    input  logic                i_pop,
    output krtc_pkg::t_event    o_data,
    output logic                o_full,
    output logic                o_empty
);

    krtc_pkg::t_event r_mem [krtc_pkg::QueueDepth];
    logic [krtc_pkg::QueueAw-1:0] r_wr, r_rd;
    logic [krtc_pkg::QueueAw:0]   r_cnt;

    assign o_full  = (r_cnt == (krtc_pkg::QueueAw+1)'(krtc_pkg::QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/krtc_back.sv =====
// Back end: expands one queued event into result transfers, one per clock while the master accepts them.
module krtc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  krtc_pkg::t_event    i_event,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic                i_tready,
    output logic                o_tvalid,
    output logic [23:0]         o_tdata,
    output logic                o_tuser,
    output logic                o_tlast
);

    logic [3:0] r_step;
    logic [3:0] w_last_step;
    logic [7:0] w_byte;
    logic       w_valid;
    logic       w_load;
    logic       w_final;

    always_comb begin
        w_last_step = 4'd0;
        w_byte      = 8'd0;
        w_valid     = 1'b1;
        unique case (i_event.kind) inside
            krtc_pkg::K_IDLE: begin
                w_valid = 1'b0;
            end
            krtc_pkg::K_STATUS: begin
                w_last_step = 4'd9;
                if (r_step == 4'd0) begin
                    w_byte = krtc_pkg::ByteStatus;
                end else if (r_step == 4'd9) begin
                    w_byte = krtc_pkg::ByteEnd;
                end else begin
                    w_byte = i_event.led[3'(r_step - 4'd1)] ? krtc_pkg::ByteLedOn
                                                            : krtc_pkg::ByteLedOff;
                end
            end
            krtc_pkg::K_CMD1, krtc_pkg::K_CMD2: begin
                w_last_step = (i_event.kind == krtc_pkg::K_CMD2) ? 4'd3 : 4'd1;
                w_byte      = r_step[0] ? krtc_pkg::ByteEnd : krtc_pkg::ByteCommand;
            end
            default: begin
                w_valid = 1'b0;
            end
        endcase
    end

    assign w_load  = (!o_tvalid || i_tready) && !i_empty;
    assign w_final = (r_step == w_last_step);
    assign o_pop   = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 4'd0;
            o_tvalid <= 1'b0;
        end else begin
            if (w_load) begin
                o_tvalid <= 1'b1;
                r_step   <= w_final ? 4'd0 : r_step + 4'd1;
            end else if (i_tready) begin
                o_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_tdata <= {7'd0, w_byte, i_event.ind, i_event.led};
            o_tuser <= w_valid;
            o_tlast <= w_final;
        end
    end

endmodule

// ===== rtl/core/keypad_relay_toggle_controller.sv =====
// Top level of the keypad relay toggle controller: config registers and pipeline wiring.
//
// Each slave transfer is one 1 ms tick with the active-low key column sample.
// The front end takes a tick in every clock while its event queue (four ticks
// deep) has room, updates debounce, blink and LED state at once, and queues one
// event. The back end turns each event into 1, 2, 4 or 10 master transfers,
// one per clock while m_axis_tready allows: a single idle transfer (tuser low)
// for a tick without a key, a 10-byte status frame for keys 1..7, and one or
// two 2-byte command frames for key 8. So the back-end serializer sets the
// sustained rate. Every transfer carries the LED byte and indicator level as of
// its tick, and tlast marks the final transfer of a tick. Write debounce_ticks
// at address 0 and blink_ticks at address 4 only while no tick is in flight;
// both are 16 bits and read back as written.
module keypad_relay_toggle_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] column_sample
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] relay_leds, [8] indicator, [16:9] tx_byte
    output logic        m_axis_tuser,   // [0] tx_valid
    output logic        m_axis_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_debounce;
    logic [15:0] r_blink;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    krtc_pkg::t_event w_push_event;
    krtc_pkg::t_event w_head_event;

    // register file: word-addressed, bit 2 picks the register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == krtc_pkg::RegBlink) ? {16'd0, r_blink}
                                                     : {16'd0, r_debounce};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= krtc_pkg::DebounceReset;
            r_blink    <= krtc_pkg::BlinkReset;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == krtc_pkg::RegBlink) begin
                r_blink <= pwdata[15:0];
            end else begin
                r_debounce <= pwdata[15:0];
            end
        end
    end

    // take a tick whenever the queue has room
    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    krtc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_sample   (s_axis_tdata),
        .i_debounce (r_debounce),
        .i_blink    (r_blink),
        .o_event    (w_push_event)
    );

    krtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_push_event),
        .i_pop   (w_pop),
        .o_data  (w_head_event),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    krtc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (w_head_event),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
